// File: rtl/mge_pkg.sv
// ----------------------------------------------------------------------------
// Mask guided edge erase package
// Shared constants and mode codes for the edge erase block.
// ----------------------------------------------------------------------------
`default_nettype none

package mge_pkg;

  // Depth of the buffer that holds a run of transparent-mask pixels.
  localparam int MAX_HELD_RUN = 64;
  localparam int IDX_W        = $clog2(MAX_HELD_RUN);

  localparam int PIX_W   = 32;
  localparam int ALPHA_W = 8;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PASS    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BARRIER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OUTSIDE = 2'd2;

endpackage

`default_nettype wire

// File: rtl/mask_guided_edge_erase.sv
// ----------------------------------------------------------------------------
// Mask guided edge erase
// Clears the parts of a scan line that lie outside a mask, or passes the line through, one pixel per item.
// ----------------------------------------------------------------------------
// A new ordinary pixel item is accepted every cycle as long as the result
// register is drained. Items that release a held run in outside mode stall
// the input while the run is replayed from the run buffer, which has one
// registered read port: each replayed pixel is read (S_RD), then loaded into
// the result register (S_WR), and the pixel that released the run is emitted
// after the run (S_TAIL). A full buffer of MAX_HELD_RUN pixels is replayed
// unchanged with the overflow flag set on every result. The run buffer needs
// no clearing after reset: only entries below the held count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module mask_guided_edge_erase (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // Configuration: erase mode.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,    // [1:0] erase_mode

  // Input pixel items.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,    // [31:0] image_pixel, [39:32] mask_alpha
  input  wire logic        in_tlast,    // line_end

  // Result items.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [31:0] out_pixel
  output logic             out_tlast,   // last_of_run
  output logic [0:0]       out_tuser    // [0] run_overflow
);

  localparam int IDX_W = mge_pkg::IDX_W;
  localparam int PIX_W = mge_pkg::PIX_W;

  typedef enum logic [1:0] {
    S_IDLE,   // accepting items
    S_RD,     // reading one held pixel from the run buffer
    S_WR,     // moving that pixel into the result register
    S_TAIL    // emitting the pixel that released the run
  } state_t;

  state_t                     state_r, state_nxt;
  logic [mge_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                       barrier_seen_r, barrier_seen_nxt;
  logic                       opaque_seen_r, opaque_seen_nxt;
  logic [IDX_W-1:0]           cnt_r, cnt_nxt;

  // Replay control.
  logic [IDX_W-1:0]           fl_idx_r, fl_idx_nxt;
  logic [IDX_W-1:0]           fl_last_r, fl_last_nxt;
  logic                       fl_zero_r, fl_zero_nxt;
  logic                       fl_ovf_r, fl_ovf_nxt;
  logic                       fl_tail_r, fl_tail_nxt;
  logic [PIX_W-1:0]           tail_pix_r, tail_pix_nxt;

  // Result register.
  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [PIX_W-1:0]           out_pix_r, out_pix_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  // Run buffer.
  logic [PIX_W-1:0]           held_mem [mge_pkg::MAX_HELD_RUN];
  logic [PIX_W-1:0]           rd_data_r;
  logic                       mem_we;

  logic                       out_free;
  logic                       in_fire;
  logic                       cfg_fire;
  logic [PIX_W-1:0]           in_pix;
  logic [mge_pkg::ALPHA_W-1:0] in_alpha;

  assign in_pix    = in_tdata[31:0];
  assign in_alpha  = in_tdata[39:32];

  // The result register is free when empty or being emptied this cycle.
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_pix_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_ovf_r;

  always_comb begin
    state_nxt        = state_r;
    mode_nxt         = mode_r;
    barrier_seen_nxt = barrier_seen_r;
    opaque_seen_nxt  = opaque_seen_r;
    cnt_nxt          = cnt_r;
    fl_idx_nxt       = fl_idx_r;
    fl_last_nxt      = fl_last_r;
    fl_zero_nxt      = fl_zero_r;
    fl_ovf_nxt       = fl_ovf_r;
    fl_tail_nxt      = fl_tail_r;
    tail_pix_nxt     = tail_pix_r;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;
    out_pix_nxt      = out_pix_r;
    out_last_nxt     = out_last_r;
    out_ovf_nxt      = out_ovf_r;
    mem_we           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (mode_r == mge_pkg::MODE_BARRIER) begin
            out_tvalid_nxt = 1'b1;
            out_last_nxt   = 1'b1;
            out_ovf_nxt    = 1'b0;
            if (barrier_seen_r) begin
              out_pix_nxt = in_pix;
            end else if (in_alpha == '0) begin
              out_pix_nxt = '0;
            end else begin
              // The first opaque mask pixel takes the mask alpha.
              barrier_seen_nxt = 1'b1;
              out_pix_nxt      = {in_alpha, in_pix[23:0]};
            end
          end else if (mode_r == mge_pkg::MODE_OUTSIDE) begin
            if (in_alpha != '0) begin
              // Opaque: the held run turned out to be inside, replay it unchanged.
              opaque_seen_nxt = 1'b1;
              cnt_nxt         = '0;
              if (cnt_r == '0) begin
                out_tvalid_nxt = 1'b1;
                out_pix_nxt    = in_pix;
                out_last_nxt   = 1'b1;
                out_ovf_nxt    = 1'b0;
              end else begin
                state_nxt    = S_RD;
                fl_idx_nxt   = '0;
                fl_last_nxt  = cnt_r - IDX_W'(1);
                fl_zero_nxt  = 1'b0;
                fl_ovf_nxt   = 1'b0;
                fl_tail_nxt  = 1'b1;
                tail_pix_nxt = in_pix;
              end
            end else if (!opaque_seen_r) begin
              // Leading transparent run.
              out_tvalid_nxt = 1'b1;
              out_pix_nxt    = '0;
              out_last_nxt   = 1'b1;
              out_ovf_nxt    = 1'b0;
            end else if (in_tlast) begin
              // Trailing run: everything held is cleared.
              cnt_nxt = '0;
              if (cnt_r == '0) begin
                out_tvalid_nxt = 1'b1;
                out_pix_nxt    = '0;
                out_last_nxt   = 1'b1;
                out_ovf_nxt    = 1'b0;
              end else begin
                state_nxt    = S_RD;
                fl_idx_nxt   = '0;
                fl_last_nxt  = cnt_r - IDX_W'(1);
                fl_zero_nxt  = 1'b1;
                fl_ovf_nxt   = 1'b0;
                fl_tail_nxt  = 1'b1;
                tail_pix_nxt = '0;
              end
            end else begin
              // Hold the pixel; a full buffer is replayed unchanged.
              mem_we = 1'b1;
              if (cnt_r == IDX_W'(mge_pkg::MAX_HELD_RUN - 1)) begin
                cnt_nxt     = '0;
                state_nxt   = S_RD;
                fl_idx_nxt  = '0;
                fl_last_nxt = IDX_W'(mge_pkg::MAX_HELD_RUN - 1);
                fl_zero_nxt = 1'b0;
                fl_ovf_nxt  = 1'b1;
                fl_tail_nxt = 1'b0;
              end else begin
                cnt_nxt = cnt_r + IDX_W'(1);
              end
            end
          end else begin
            out_tvalid_nxt = 1'b1;
            out_pix_nxt    = in_pix;
            out_last_nxt   = 1'b1;
            out_ovf_nxt    = 1'b0;
          end

          if (in_tlast) begin
            barrier_seen_nxt = 1'b0;
            opaque_seen_nxt  = 1'b0;
            cnt_nxt          = '0;
          end
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_pix_nxt    = fl_zero_r ? '0 : rd_data_r;
          out_last_nxt   = !fl_tail_r && (fl_idx_r == fl_last_r);
          out_ovf_nxt    = fl_ovf_r;
          if (fl_idx_r == fl_last_r) begin
            state_nxt = fl_tail_r ? S_TAIL : S_IDLE;
          end else begin
            fl_idx_nxt = fl_idx_r + IDX_W'(1);
            state_nxt  = S_RD;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_pix_nxt    = tail_pix_r;
          out_last_nxt   = 1'b1;
          out_ovf_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A mode write starts a fresh line and drops any held run.
    if (cfg_fire) begin
      mode_nxt         = cfg_data;
      barrier_seen_nxt = 1'b0;
      opaque_seen_nxt  = 1'b0;
      cnt_nxt          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      mode_r         <= mge_pkg::MODE_PASS;
      barrier_seen_r <= 1'b0;
      opaque_seen_r  <= 1'b0;
      cnt_r          <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      mode_r         <= mode_nxt;
      barrier_seen_r <= barrier_seen_nxt;
      opaque_seen_r  <= opaque_seen_nxt;
      cnt_r          <= cnt_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
    end
    fl_idx_r   <= fl_idx_nxt;
    fl_last_r  <= fl_last_nxt;
    fl_zero_r  <= fl_zero_nxt;
    fl_ovf_r   <= fl_ovf_nxt;
    fl_tail_r  <= fl_tail_nxt;
    tail_pix_r <= tail_pix_nxt;
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // Run buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      held_mem[cnt_r] <= in_pix;
    end
    if (state_r == S_RD) begin
      rd_data_r <= held_mem[fl_idx_r];
    end
  end

  // The replay index never runs past the end of the run.
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_WR) |-> fl_idx_r <= fl_last_r)
    else $error("replay index beyond end of run");

  // An opaque pixel arriving on a nonempty run starts a replay.
  a_release_replays: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode_r == mge_pkg::MODE_OUTSIDE && in_alpha != '0 && cnt_r != '0)
      |=> state_r == S_RD)
    else $error("held run not replayed on opaque pixel");

  // Only a run released by a pixel has a tail pixel.
  a_tail_marked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAIL |-> fl_tail_r)
    else $error("tail state without a releasing pixel");

  // An overflow replay is unchanged and has no tail.
  a_ovf_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR && fl_ovf_r) |-> (!fl_tail_r && !fl_zero_r))
    else $error("overflow replay with tail or clearing");

endmodule

`default_nettype wire

// File: bench/tb_mask_guided_edge_erase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mask guided edge erase testbench
// Drives pixel lines in every erase mode under random source gaps and sink
// stalls, predicts every result pixel in a scoreboard and checks them in order.
// ----------------------------------------------------------------------------

class edge_erase_scoreboard;

  typedef struct packed {
    logic [mge_pkg::PIX_W-1:0] pixel;
    logic                      last;
    logic                      overflow;
  } erased_pixel_t;

  logic [mge_pkg::MODE_W-1:0] mode;
  bit                         barrier_seen;
  bit                         opaque_seen;
  int                         held_count;
  logic [mge_pkg::PIX_W-1:0]  held_pixels [mge_pkg::MAX_HELD_RUN];
  erased_pixel_t              pending_pixels [$];
  int                         errors;

  function new();
    mode         = mge_pkg::MODE_PASS;
    barrier_seen = 0;
    opaque_seen  = 0;
    held_count   = 0;
    errors       = 0;
  endfunction

  function int pending();
    return pending_pixels.size();
  endfunction

  // A mode write also forgets the line state and any held run.
  function void set_mode(logic [mge_pkg::MODE_W-1:0] m);
    mode         = m;
    barrier_seen = 0;
    opaque_seen  = 0;
    held_count   = 0;
  endfunction

  function void push(logic [mge_pkg::PIX_W-1:0] pix, logic last, logic ovf);
    erased_pixel_t e;
    e.pixel    = pix;
    e.last     = last;
    e.overflow = ovf;
    pending_pixels.push_back(e);
  endfunction

  // Works out the result pixels that one accepted input pixel produces.
  function void note_pixel(logic [mge_pkg::PIX_W-1:0] pix, logic [mge_pkg::ALPHA_W-1:0] ma,
                           logic eol);
    logic [mge_pkg::PIX_W-1:0] r;
    case (mode)
      mge_pkg::MODE_BARRIER: begin
        if (barrier_seen) begin
          r = pix;
        end else if (ma == 0) begin
          r = '0;
        end else begin
          barrier_seen = 1;
          r = {ma, pix[23:0]};
        end
        push(r, 1'b1, 1'b0);
      end
      mge_pkg::MODE_OUTSIDE: begin
        if (ma != 0) begin
          // The held run lay between two opaque pixels, so it survives.
          for (int i = 0; i < held_count; i++) push(held_pixels[i], 1'b0, 1'b0);
          held_count  = 0;
          opaque_seen = 1;
          push(pix, 1'b1, 1'b0);
        end else if (!opaque_seen) begin
          push('0, 1'b1, 1'b0);
        end else if (eol) begin
          // Trailing run: everything held plus this pixel is cleared.
          for (int i = 0; i < held_count; i++) push('0, 1'b0, 1'b0);
          held_count = 0;
          push('0, 1'b1, 1'b0);
        end else begin
          held_pixels[held_count] = pix;
          held_count++;
          if (held_count == mge_pkg::MAX_HELD_RUN) begin
            for (int i = 0; i < mge_pkg::MAX_HELD_RUN; i++)
              push(held_pixels[i], (i == mge_pkg::MAX_HELD_RUN - 1), 1'b1);
            held_count = 0;
          end
        end
      end
      default: push(pix, 1'b1, 1'b0);
    endcase
    if (eol) begin
      barrier_seen = 0;
      opaque_seen  = 0;
      held_count   = 0;
    end
  endfunction

  task report_mismatch(string msg);
    if (errors < 40) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_result(logic [mge_pkg::PIX_W-1:0] pix, logic last, logic ovf);
    erased_pixel_t e;
    if (pending_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected result pixel %08h", pix));
    end else begin
      e = pending_pixels.pop_front();
      if (pix !== e.pixel)
        report_mismatch($sformatf("pixel %08h, wanted %08h", pix, e.pixel));
      if (last !== e.last)
        report_mismatch($sformatf("last flag %b, wanted %b (pixel %08h)", last, e.last,
                                  e.pixel));
      if (ovf !== e.overflow)
        report_mismatch($sformatf("overflow flag %b, wanted %b (pixel %08h)", ovf,
                                  e.overflow, e.pixel));
    end
  endtask

endclass

module tb_mask_guided_edge_erase;

  // The fourth mode code is not named in the package; the block treats it as
  // pass through.
  localparam logic [mge_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;   // long sink hold-off
  localparam int SETTLE       = 20;    // quiet cycles before a mode write
  localparam int TAIL_CYCLES  = 200;   // margin for the longest replay

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         cfg_valid  = 1'b0;
  logic                         cfg_ready;
  logic [mge_pkg::MODE_W-1:0]   cfg_data   = '0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [39:0]                  in_tdata   = '0;  // [31:0] image_pixel, [39:32] mask_alpha
  logic                         in_tlast   = 1'b0; // line_end
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [31:0]                  out_tdata;        // [31:0] out_pixel
  logic                         out_tlast;        // last_of_run
  logic [0:0]                   out_tuser;        // [0] run_overflow

  edge_erase_scoreboard sb;

  int        cycles     = 0;
  int        burst_left = 0;
  bit        hold_req   = 0;
  int        hold_left  = 0;
  int        pat_age    = 0;
  logic [15:0] ready_pat = 16'hFFFF;

  mask_guided_edge_erase u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL mask_guided_edge_erase");
      $finish;
    end
  end

  // Every result item is checked against the oldest predicted pixel. Values
  // are read right after the rising edge, before the block's flops update.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tlast, out_tuser[0]);
  end

  // The sink stalls on a rotating 16-bit pattern that is redrawn when pat_age
  // runs out; one draw in four is all ones, which gives stall-free stretches.
  // A hold-off request keeps tready low until HOLD_CYCLES has counted down here.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age = 40;
        case ($urandom_range(3))
          0:       ready_pat = 16'hFFFF;
          1:       ready_pat = 16'($urandom);
          2:       ready_pat = 16'($urandom & $urandom);
          default: ready_pat = 16'($urandom | $urandom);
        endcase
      end
      pat_age--;
      out_tready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  // Offers one pixel item from a falling edge and returns at the falling edge
  // after it was taken. The source runs in bursts; at the end of a burst it
  // drops tvalid for a random gap before the next item.
  task automatic send_pixel(logic [31:0] pix, logic [7:0] ma, logic eol);
    in_tdata  <= {ma, pix};
    in_tlast  <= eol;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(pix, ma, eol);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(5) == 0) ? 60 : $urandom_range(1, 12);
    end
  endtask

  // Mask alpha is zero about (100 - pct) percent of the time; the nonzero
  // values lean on the extremes 1 and 255.
  function automatic logic [7:0] pick_alpha(int pct);
    if ($urandom_range(99) >= pct) return 8'h00;
    case ($urandom_range(3))
      0:       return 8'hFF;
      1:       return 8'h01;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // A line of random pixels; most lines are closed by line_end, a few are
  // left open so that a mode write has to drop their state.
  task automatic send_line(int len, int pct);
    logic close;
    close = ($urandom_range(7) != 0);
    for (int i = 0; i < len; i++)
      send_pixel($urandom, pick_alpha(pct), close && (i == len - 1));
  endtask

  // Opaque pixel, then a run of transparent-mask pixels, then the line end
  // pixel with the given mask alpha.
  task automatic send_long_run(int held, logic [7:0] end_alpha);
    send_pixel($urandom, 8'hFF, 1'b0);
    repeat (held) send_pixel($urandom, 8'h00, 1'b0);
    send_pixel($urandom, end_alpha, 1'b1);
  endtask

  // Stops the source and waits until the block has delivered every predicted
  // pixel, then a little longer in case it is still storing a held pixel.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(logic [mge_pkg::MODE_W-1:0] m);
    settle_block();
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_mode(m);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  logic [mge_pkg::MODE_W-1:0] phase_modes [8];

  initial begin
    int n;
    int len;
    sb = new();
    phase_modes = '{mge_pkg::MODE_PASS, mge_pkg::MODE_BARRIER, mge_pkg::MODE_OUTSIDE,
                    MODE_SPARE, mge_pkg::MODE_OUTSIDE, mge_pkg::MODE_BARRIER,
                    mge_pkg::MODE_OUTSIDE, mge_pkg::MODE_PASS};

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Pass through straight from reset, field extremes.
    send_pixel(32'hFFFF_FFFF, 8'hFF, 1'b0);
    send_pixel(32'h0000_0000, 8'h00, 1'b1);

    // The spare mode code passes pixels through.
    write_mode(MODE_SPARE);
    send_pixel(32'h1234_5678, 8'h00, 1'b0);
    send_pixel(32'hA5A5_A5A5, 8'h80, 1'b1);

    // Barrier: two cleared pixels, the barrier pixel takes the mask alpha,
    // then pass through to the line end; a new line opens on an opaque pixel.
    write_mode(mge_pkg::MODE_BARRIER);
    send_pixel(32'hFFFF_FFFF, 8'h00, 1'b0);
    send_pixel(32'h1122_3344, 8'h00, 1'b0);
    send_pixel(32'hDEAD_BEEF, 8'h7F, 1'b0);
    send_pixel(32'hCAFE_F00D, 8'h00, 1'b1);
    send_pixel(32'h0000_0000, 8'hFF, 1'b1);

    // Outside: leading clear, a held run released by an opaque pixel, then a
    // trailing run cleared at the line end.
    write_mode(mge_pkg::MODE_OUTSIDE);
    send_pixel(32'h0000_00AA, 8'h00, 1'b0);
    send_pixel(32'h0000_00BB, 8'h01, 1'b0);
    send_pixel(32'h0000_00CC, 8'h00, 1'b0);
    send_pixel(32'h0000_00DD, 8'h00, 1'b0);
    send_pixel(32'h0000_00EE, 8'hFF, 1'b0);
    send_pixel(32'h0000_00FF, 8'h00, 1'b0);
    send_pixel(32'h0000_0011, 8'h00, 1'b1);
    // A one-pixel line with no opaque pixel is cleared.
    send_pixel(32'h0000_0022, 8'h00, 1'b1);
    // Leave a run held; the mode write below must drop it.
    send_pixel(32'h0000_0033, 8'h09, 1'b0);
    send_pixel(32'h0000_0044, 8'h00, 1'b0);
    write_mode(mge_pkg::MODE_OUTSIDE);
    send_pixel(32'h0000_0055, 8'h00, 1'b0);
    send_pixel(32'h0000_0066, 8'h01, 1'b1);

    // Random part: one mode per phase, short lines with random content.
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(phase_modes[ph]);
      // First phase: the sink holds off while the source keeps offering,
      // so the block fills up and backs up its input.
      if (ph == 0) hold_req = 1;
      n = 0;
      while (n < 3) begin
        len = $urandom_range(1, 6);
        // One line in five is noise with mostly opaque mask pixels.
        send_line(len, ($urandom_range(4) == 0) ? 90 : 35);
        n += len;
      end
      // A full run buffer flushes unchanged; the two held after it are then
      // cleared by the trailing line end.
      if (ph == 2) send_long_run(66, 8'h00);
      // A run released by an opaque line-end pixel.
      if (ph == 4) send_long_run(8, 8'hFF);
    end

    settle_block();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d predicted pixels never arrived", sb.pending()));

    if (sb.errors == 0)
      $display("PASS mask_guided_edge_erase");
    else
      $display("FAIL mask_guided_edge_erase");
    $finish;
  end

endmodule
